>>> sv/mmfp_pkg.sv
package mmfp_pkg;

  localparam int unsigned WindowWords = 8;
  localparam int unsigned PhyRegCount = 32;
  localparam int unsigned WinIdxW = $clog2(WindowWords);
  localparam int unsigned PhyAddrW = $clog2(PhyRegCount);

  localparam logic [WinIdxW-1:0] WFrame  = 3'd3;
  localparam logic [WinIdxW-1:0] WConfig = 3'd4;
  localparam logic [WinIdxW-1:0] WMask   = 3'd5;
  localparam logic [WinIdxW-1:0] WStatus = 3'd6;

  localparam logic FuncRead  = 1'b0;
  localparam logic FuncWrite = 1'b1;

  localparam logic [1:0] StartCode = 2'd1;
  localparam logic [1:0] OpWrite   = 2'd1;
  localparam logic [1:0] OpRead    = 2'd2;
  localparam logic [4:0] PhyAddr   = 5'd1;

  localparam logic [31:0] ConfigReset = 32'h0000_0100;
  localparam logic [31:0] MaskReset   = 32'h0000_ffff;
  localparam logic [31:0] CfgSense    = 32'h0000_0300;

  localparam logic [PhyAddrW-1:0] PhyCtrl   = 5'd0;
  localparam logic [PhyAddrW-1:0] PhyStat   = 5'd1;
  localparam logic [PhyAddrW-1:0] PhyAnAdv  = 5'd4;
  localparam logic [PhyAddrW-1:0] PhyAnLpa  = 5'd5;

  localparam logic [15:0] PhyStatReset = 16'h4000;
  localparam logic [15:0] PhyAnAdvReset = 16'h0100;

  typedef struct packed {
    logic                we;
    logic [PhyAddrW-1:0] addr;
    logic [15:0]         data;
  } phy_req_t;

endpackage

>>> sv/mmfp_phy.sv
module mmfp_phy (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mmfp_pkg::phy_req_t             req_i,
  input  logic [mmfp_pkg::PhyAddrW-1:0]  rd_addr_i,
  output logic [15:0]                    rd_data_o
);

  logic [15:0] regs_q [mmfp_pkg::PhyRegCount];
  logic [15:0] wdata;
  logic        restart;

  assign rd_data_o = regs_q[rd_addr_i];

  // control register: reset self-clears into autoneg enable, restart completes autoneg
  always_comb begin
    wdata   = req_i.data;
    restart = 1'b0;
    if (req_i.addr == mmfp_pkg::PhyCtrl) begin
      if (wdata[15]) begin
        wdata[15] = 1'b0;
        wdata[12] = 1'b1;
      end
      if (wdata[9]) begin
        wdata[9] = 1'b0;
        restart  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mmfp_pkg::PhyRegCount; i++) begin
        if (mmfp_pkg::PhyAddrW'(i) == mmfp_pkg::PhyStat) begin
          regs_q[mmfp_pkg::PhyAddrW'(i)] <= mmfp_pkg::PhyStatReset;
        end else if (mmfp_pkg::PhyAddrW'(i) == mmfp_pkg::PhyAnAdv) begin
          regs_q[mmfp_pkg::PhyAddrW'(i)] <= mmfp_pkg::PhyAnAdvReset;
        end else begin
          regs_q[mmfp_pkg::PhyAddrW'(i)] <= '0;
        end
      end
    end else if (req_i.we) begin
      if (restart) begin
        regs_q[mmfp_pkg::PhyAnLpa] <= regs_q[mmfp_pkg::PhyAnLpa] | 16'h0100;
        regs_q[mmfp_pkg::PhyStat]  <= regs_q[mmfp_pkg::PhyStat] | 16'h0024;
      end
      regs_q[req_i.addr] <= wdata;
    end
  end

endmodule

>>> sv/mmfp_window.sv
module mmfp_window (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  logic                          func_i,
  input  logic [mmfp_pkg::WinIdxW-1:0]  reg_index_i,
  input  logic [31:0]                   write_data_i,
  input  logic [15:0]                   phy_rd_data_i,
  output logic [mmfp_pkg::PhyAddrW-1:0] phy_rd_addr_o,
  output mmfp_pkg::phy_req_t            phy_req_o,
  output logic [31:0]                   read_data_o
);

  logic [31:0] win_q [mmfp_pkg::WindowWords];
  logic [31:0] wval;
  logic        frame_ok;
  logic [1:0]  opc;

  assign opc           = write_data_i[29:28];
  assign phy_rd_addr_o = write_data_i[22:18];
  assign frame_ok      = (write_data_i[31:30] == mmfp_pkg::StartCode) &&
                         (write_data_i[27:23] == mmfp_pkg::PhyAddr);

  always_comb begin
    wval            = write_data_i;
    phy_req_o.we    = 1'b0;
    phy_req_o.addr  = write_data_i[22:18];
    phy_req_o.data  = write_data_i[15:0];
    if (reg_index_i == mmfp_pkg::WConfig) begin
      wval = (write_data_i & ~mmfp_pkg::CfgSense) |
             (win_q[mmfp_pkg::WConfig] & mmfp_pkg::CfgSense);
    end else if (reg_index_i == mmfp_pkg::WFrame && frame_ok) begin
      if (opc == mmfp_pkg::OpWrite) begin
        phy_req_o.we = fire_i && (func_i == mmfp_pkg::FuncWrite);
      end else if (opc == mmfp_pkg::OpRead) begin
        wval[15:0] = phy_rd_data_i;
      end
      wval[16] = 1'b1;
    end
  end

  assign read_data_o = (func_i == mmfp_pkg::FuncWrite) ? '0 : win_q[reg_index_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mmfp_pkg::WindowWords; i++) begin
        if (mmfp_pkg::WinIdxW'(i) == mmfp_pkg::WConfig) begin
          win_q[mmfp_pkg::WinIdxW'(i)] <= mmfp_pkg::ConfigReset;
        end else if (mmfp_pkg::WinIdxW'(i) == mmfp_pkg::WMask) begin
          win_q[mmfp_pkg::WinIdxW'(i)] <= mmfp_pkg::MaskReset;
        end else begin
          win_q[mmfp_pkg::WinIdxW'(i)] <= '0;
        end
      end
    end else if (fire_i) begin
      if (func_i == mmfp_pkg::FuncWrite) begin
        win_q[reg_index_i] <= wval;
      end else if (reg_index_i == mmfp_pkg::WStatus) begin
        win_q[mmfp_pkg::WStatus] <= '0;
      end
    end
  end

endmodule

>>> sv/mii_management_frame_phy_model.sv
// Throughput: one request per cycle while out_stall_i does not hold the
// output; the window and PHY register files are updated in the single stage
// between the input and result registers, when the result register is free.
// Reset (async, active low) empties both registers and restores the window
// (config 0x100, mask 0xffff) and PHY registers (reg 1 0x4000, reg 4 0x0100).
module mii_management_frame_phy_model (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [2:0]  reg_index_i,
  input  logic [31:0] write_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_data_o
);

  logic        s1_valid_q;
  logic        func_q;
  logic [2:0]  idx_q;
  logic [31:0] wdata_q;
  logic        out_valid_q;
  logic [31:0] rdata_q;
  logic        out_free;
  logic        fire;
  logic        accept;
  logic [31:0] result;
  logic [mmfp_pkg::PhyAddrW-1:0] phy_rd_addr;
  logic [15:0] phy_rd_data;
  mmfp_pkg::phy_req_t phy_req;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign fire        = s1_valid_q && out_free;
  assign in_stall_o  = s1_valid_q && !out_free;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign read_data_o = rdata_q;

  mmfp_window u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .func_i        (func_q),
    .reg_index_i   (idx_q),
    .write_data_i  (wdata_q),
    .phy_rd_data_i (phy_rd_data),
    .phy_rd_addr_o (phy_rd_addr),
    .phy_req_o     (phy_req),
    .read_data_o   (result)
  );

  mmfp_phy u_phy (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (phy_req),
    .rd_addr_i (phy_rd_addr),
    .rd_data_o (phy_rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (fire) begin
        s1_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= func_i;
      idx_q   <= reg_index_i;
      wdata_q <= write_data_i;
    end
    if (fire) begin
      rdata_q <= result;
    end
  end

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty stage");

  a_held_item_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |=> s1_valid_q)
    else $error("blocked request lost");

  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && func_q == mmfp_pkg::FuncWrite) |=> (out_valid_o && read_data_o == '0))
    else $error("write result not zero");

endmodule
